// ===== rtl/wsd_pkg.sv =====
// shared types and constants of the websocket frame deframer
package wsd_pkg;

   // maximum width of a declared payload length
   localparam int LENGTH_BITS = 64;
   // stored length width: the top bit of a 64-bit length is always dropped
   localparam int LEN_W = (LENGTH_BITS > 63) ? 63 : LENGTH_BITS;
   localparam int PLEN_W = 63;

   // result kinds
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_UNMASKED = 3'd1;
   localparam logic [2:0] ERR_RSV      = 3'd2;
   localparam logic [2:0] ERR_OPCODE   = 3'd3;
   localparam logic [2:0] ERR_CONTROL  = 3'd4;

   // opcodes
   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_BIN   = 4'h2;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   // length codes of the second header byte
   localparam logic [6:0] LEN_CTRL_MAX = 7'd125;
   localparam logic [6:0] LEN_EXT16    = 7'd126;
   localparam logic [6:0] LEN_EXT64    = 7'd127;

   typedef struct packed {
      logic              valid;
      logic [1:0]        kind;
      logic [7:0]        data_byte;
      logic [3:0]        opcode;
      logic              fin_flag;
      logic              last;
      logic [2:0]        error_code;
      logic [PLEN_W-1:0] payload_len;
   } result_type;

endpackage

// ===== rtl/websocket_frame_deframer.sv =====
// websocket frame deframer top level
//
// Takes the client-to-server byte stream on req_* one byte per transfer and
// gives one result per payload byte on rsp_*: the unmasked byte with the
// frame's opcode, fin bit and declared length, tlast on the final byte.
// A frame with no payload gives one empty-frame marker (tuser kind 1).
// A bad header (unmasked, reserved bits, unknown opcode, oversized or
// fragmented control frame) gives one error result (kind 2) with tlast, and
// after it the block drops every byte until reset.
// A transferred byte is held in the input register and its result in the
// result register; throughput is one byte per cycle while rsp_tready does
// not stall, set by the single parser step between those two registers.
// When rsp_tready is low with a result waiting, the parser holds; an empty
// input register still takes one byte, then req_tready stays low until the
// result drains.
// Reset is synchronous and returns the parser to expect a frame header,
// with both registers empty.
module websocket_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // data_byte[7:0], opcode[11:8], fin_flag[12],
                                    // error_code[15:13], payload_len[78:16], zero[79]
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic        rsp_tlast
);

   logic                take;
   logic                byte_valid;
   logic [7:0]          byte_data;
   logic                slot_free;
   wsd_pkg::result_type res;

   wsd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   wsd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .slot_free  (slot_free),
      .take       (take),
      .res        (res)
   );

   wsd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .res        (res),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/wsd_in_stage.sv =====
// input register of the deframer: holds one received byte until the parser takes it
module wsd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte[7:0]
   input  logic       take,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;

   assign req_tready = !valid_ff || take;
   assign valid_in   = (req_tvalid && req_tready) ? 1'b1 : (take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         data_ff <= req_tdata;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

// ===== rtl/wsd_parser.sv =====
// frame parser: header checks, length and mask assembly, payload unmasking
module wsd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_valid,
   input  logic [7:0]          byte_data,
   input  logic                slot_free,
   output logic                take,
   output wsd_pkg::result_type res
);

   localparam logic [2:0] PH_HDR0 = 3'd0;
   localparam logic [2:0] PH_HDR1 = 3'd1;
   localparam logic [2:0] PH_EXT  = 3'd2;
   localparam logic [2:0] PH_MASK = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;

   logic [2:0]                 phase_ff, phase_in;
   logic [3:0]                 opcode_ff, opcode_in;
   logic                       fin_ff, fin_in;
   logic [2:0]                 rsv_ff, rsv_in;
   logic [6:0]                 len_kind_ff, len_kind_in;
   logic [2:0]                 count_ff, count_in;
   logic [wsd_pkg::LEN_W-1:0]  length_ff, length_in;
   logic [31:0]                key_ff, key_in;
   logic [wsd_pkg::LEN_W-1:0]  remain_ff, remain_in;
   logic [1:0]                 mphase_ff, mphase_in;
   logic                       failed_ff, failed_in;

   logic [2:0]                 err;
   logic [7:0]                 key_byte;
   logic [2:0]                 count_inc;
   logic [wsd_pkg::LEN_W-1:0]  remain_dec;
   logic [wsd_pkg::LEN_W-1:0]  length_shift;

   assign take = byte_valid && slot_free;

   // header checks on the second header byte, in priority order
   always_comb begin
      err = wsd_pkg::ERR_NONE;
      if (!byte_data[7]) begin
         err = wsd_pkg::ERR_UNMASKED;
      end else if (rsv_ff != 3'd0) begin
         err = wsd_pkg::ERR_RSV;
      end else if (opcode_ff == wsd_pkg::OP_CONT || opcode_ff == wsd_pkg::OP_TEXT ||
                   opcode_ff == wsd_pkg::OP_BIN) begin
         err = wsd_pkg::ERR_NONE;
      end else if (opcode_ff == wsd_pkg::OP_CLOSE || opcode_ff == wsd_pkg::OP_PING ||
                   opcode_ff == wsd_pkg::OP_PONG) begin
         if (byte_data[6:0] > wsd_pkg::LEN_CTRL_MAX || !fin_ff) begin
            err = wsd_pkg::ERR_CONTROL;
         end
      end else begin
         err = wsd_pkg::ERR_OPCODE;
      end
   end

   // first mask byte sits in the top of the key
   always_comb begin
      case (mphase_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   assign count_inc    = count_ff + 3'd1;
   assign remain_dec   = remain_ff - wsd_pkg::LEN_W'(1);
   assign length_shift = {length_ff[wsd_pkg::LEN_W-9:0], byte_data};

   always_comb begin
      phase_in    = phase_ff;
      opcode_in   = opcode_ff;
      fin_in      = fin_ff;
      rsv_in      = rsv_ff;
      len_kind_in = len_kind_ff;
      count_in    = count_ff;
      length_in   = length_ff;
      key_in      = key_ff;
      remain_in   = remain_ff;
      mphase_in   = mphase_ff;
      failed_in   = failed_ff;

      res             = '0;
      res.opcode      = opcode_ff;
      res.fin_flag    = fin_ff;

      if (take && !failed_ff) begin
         unique case (phase_ff)
            PH_HDR0: begin
               fin_in    = byte_data[7];
               rsv_in    = byte_data[6:4];
               opcode_in = byte_data[3:0];
               phase_in  = PH_HDR1;
            end
            PH_HDR1: begin
               if (err != wsd_pkg::ERR_NONE) begin
                  failed_in      = 1'b1;
                  res.valid      = 1'b1;
                  res.kind       = wsd_pkg::KIND_ERROR;
                  res.last       = 1'b1;
                  res.error_code = err;
               end else begin
                  len_kind_in = byte_data[6:0];
                  count_in    = 3'd0;
                  if (byte_data[6:0] == wsd_pkg::LEN_EXT16 ||
                      byte_data[6:0] == wsd_pkg::LEN_EXT64) begin
                     length_in = '0;
                     phase_in  = PH_EXT;
                  end else begin
                     length_in = wsd_pkg::LEN_W'(byte_data[6:0]);
                     phase_in  = PH_MASK;
                  end
               end
            end
            PH_EXT: begin
               length_in = length_shift;
               count_in  = count_inc;
               if ((len_kind_ff == wsd_pkg::LEN_EXT16 && count_inc == 3'd2) ||
                   (len_kind_ff != wsd_pkg::LEN_EXT16 && count_inc == 3'd0)) begin
                  count_in = 3'd0;
                  phase_in = PH_MASK;
               end
            end
            PH_MASK: begin
               key_in   = {key_ff[23:0], byte_data};
               count_in = count_inc;
               if (count_inc == 3'd4) begin
                  count_in  = 3'd0;
                  mphase_in = 2'd0;
                  remain_in = length_ff;
                  if (length_ff == '0) begin
                     phase_in  = PH_HDR0;
                     res.valid = 1'b1;
                     res.kind  = wsd_pkg::KIND_EMPTY;
                     res.last  = 1'b1;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               mphase_in       = mphase_ff + 2'd1;
               remain_in       = remain_dec;
               res.valid       = 1'b1;
               res.kind        = wsd_pkg::KIND_DATA;
               res.data_byte   = byte_data ^ key_byte;
               res.payload_len = wsd_pkg::PLEN_W'(length_ff);
               if (remain_dec == '0) begin
                  res.last = 1'b1;
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR0;
         opcode_ff   <= '0;
         fin_ff      <= 1'b0;
         rsv_ff      <= '0;
         len_kind_ff <= '0;
         count_ff    <= '0;
         length_ff   <= '0;
         key_ff      <= '0;
         remain_ff   <= '0;
         mphase_ff   <= '0;
         failed_ff   <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         opcode_ff   <= opcode_in;
         fin_ff      <= fin_in;
         rsv_ff      <= rsv_in;
         len_kind_ff <= len_kind_in;
         count_ff    <= count_in;
         length_ff   <= length_in;
         key_ff      <= key_in;
         remain_ff   <= remain_in;
         mphase_ff   <= mphase_in;
         failed_ff   <= failed_in;
      end
   end

`ifndef SYNTHESIS
   // once an error went out the parser stays silent
   a_silent_after_error: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> !res.valid)
      else $error("result after error");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (res.valid && res.kind == wsd_pkg::KIND_ERROR) |=> failed_ff)
      else $error("error did not latch failed state");

   a_last_byte_rearms: assert property (@(posedge clock) disable iff (reset)
      (res.valid && res.kind == wsd_pkg::KIND_DATA && res.last) |=> phase_ff == PH_HDR0)
      else $error("last payload byte did not return to header");

   a_data_only_in_payload: assert property (@(posedge clock) disable iff (reset)
      (res.valid && res.kind == wsd_pkg::KIND_DATA) |-> (phase_ff == PH_DATA && remain_ff != '0))
      else $error("payload byte outside payload phase");
`endif

endmodule

// ===== rtl/wsd_out_stage.sv =====
// result register of the deframer, packs results onto the stream port
module wsd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  wsd_pkg::result_type res,
   output logic                slot_free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [79:0]         rsp_tdata,  // data_byte[7:0], opcode[11:8], fin_flag[12],
                                           // error_code[15:13], payload_len[78:16], zero[79]
   output logic [1:0]          rsp_tuser,  // kind[1:0]
   output logic                rsp_tlast
);

   logic                valid_ff, valid_in;
   wsd_pkg::result_type res_ff;

   assign slot_free = !valid_ff || rsp_tready;
   assign valid_in  = res.valid ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tlast  = res_ff.last;
   assign rsp_tdata  = {1'b0, res_ff.payload_len, res_ff.error_code, res_ff.fin_flag,
                        res_ff.opcode, res_ff.data_byte};

endmodule
